### rtl/kmcc_pkg.sv
`default_nettype none
package kmcc_pkg;
    localparam int MAX_CENTERS = 16;
    localparam int PIXEL_COUNT_LOG2 = 20;
    localparam int IDX_W = $clog2(MAX_CENTERS);
    localparam int K_W = $clog2(MAX_CENTERS + 1);
    localparam int SUM_W = PIXEL_COUNT_LOG2 + 8;
    localparam int CNT_W = PIXEL_COUNT_LOG2 + 1;
    localparam int DIST_W = 18;
    localparam logic [23:0] LFSR_MASK = 24'hE10000;

    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_CLASSIFY = 2'd1;
    localparam logic [1:0] FUNC_ENDGEN  = 2'd2;
    localparam logic [1:0] FUNC_RECOLOR = 2'd3;

    localparam logic [1:0] REG_ACTIVE = 2'd0;
    localparam logic [1:0] REG_LIMIT  = 2'd1;
    localparam logic [1:0] REG_SEED   = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] center_index;
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
    } t_in_item;

    typedef struct packed {
        logic [3:0] label;
        logic [7:0] center_red;
        logic [7:0] center_green;
        logic [7:0] center_blue;
        logic       converged;
    } t_out_item;

    // token that travels down the cell chain during classify
    typedef struct packed {
        logic              vld;
        logic [7:0]        r;
        logic [7:0]        g;
        logic [7:0]        b;
        logic [DIST_W:0]   best_d;
        logic [IDX_W-1:0]  best;
    } t_cls_tok;

    // control of one cell from the sequencer
    typedef struct packed {
        logic              load;
        logic [23:0]       load_rgb;
        logic              upd;
        logic [23:0]       upd_rgb;
        logic              clr;
        logic              add;
        logic [7:0]        add_r;
        logic [7:0]        add_g;
        logic [7:0]        add_b;
    } t_cell_ctl;

    typedef struct packed {
        logic [23:0]       rgb;
        logic [SUM_W-1:0]  rs;
        logic [SUM_W-1:0]  gs;
        logic [SUM_W-1:0]  bs;
        logic [CNT_W-1:0]  cnt;
    } t_cell_st;
endpackage
`default_nettype wire

### rtl/kmcc_cell.sv
`default_nettype none
module kmcc_cell
    import kmcc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [IDX_W-1:0]  i_my_idx,
    input  wire logic              i_active,
    input  wire t_cls_tok          i_tok,
    output t_cls_tok               o_tok,
    input  wire t_cell_ctl         i_ctl,
    output t_cell_st               o_st
);
    logic [23:0] r_rgb;
    logic [SUM_W-1:0] r_rs, r_gs, r_bs;
    logic [CNT_W-1:0] r_cnt;
    t_cls_tok r_tok, n_tok;

    logic signed [8:0] dr, dg, db;
    logic signed [17:0] sq_r, sq_g, sq_b;
    logic [DIST_W:0] d;
    logic [SUM_W:0] sr, sg, sb;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    always_comb begin
        dr = $signed({1'b0, r_rgb[23:16]}) - $signed({1'b0, i_tok.r});
        dg = $signed({1'b0, r_rgb[15:8]}) - $signed({1'b0, i_tok.g});
        db = $signed({1'b0, r_rgb[7:0]}) - $signed({1'b0, i_tok.b});
        sq_r = dr * dr;
        sq_g = dg * dg;
        sq_b = db * db;
        d = {1'b0, sq_r} + {1'b0, sq_g} + {1'b0, sq_b};
        sr = {1'b0, r_rs} + (SUM_W+1)'(i_ctl.add_r);
        sg = {1'b0, r_gs} + (SUM_W+1)'(i_ctl.add_g);
        sb = {1'b0, r_bs} + (SUM_W+1)'(i_ctl.add_b);
        n_tok = i_tok;
        if (i_tok.vld && i_active && d < i_tok.best_d) begin
            n_tok.best_d = d;
            n_tok.best = i_my_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rgb <= '0;
            r_rs <= '0;
            r_gs <= '0;
            r_bs <= '0;
            r_cnt <= '0;
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_ctl.load) r_rgb <= i_ctl.load_rgb;
            else if (i_ctl.upd) r_rgb <= i_ctl.upd_rgb;
            if (i_ctl.clr) begin
                r_rs <= '0;
                r_gs <= '0;
                r_bs <= '0;
                r_cnt <= '0;
            end else if (i_ctl.add && r_cnt != '1) begin
                r_cnt <= r_cnt + 1'b1;
                r_rs <= sr[SUM_W] ? SUM_MAX : sr[SUM_W-1:0];
                r_gs <= sg[SUM_W] ? SUM_MAX : sg[SUM_W-1:0];
                r_bs <= sb[SUM_W] ? SUM_MAX : sb[SUM_W-1:0];
            end
        end
    end

    assign o_tok = r_tok;
    assign o_st = '{rgb: r_rgb, rs: r_rs, gs: r_gs, bs: r_bs, cnt: r_cnt};
endmodule
`default_nettype wire

### rtl/kmcc_div.sv
`default_nettype none
module kmcc_div
    import kmcc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SUM_W-1:0]  i_num,
    input  wire logic [CNT_W-1:0]  i_den,
    output logic                   o_done,
    output logic [7:0]             o_quo
);
    // restoring divider, one quotient bit per cycle, saturated to 255
    localparam int STEPS = SUM_W;
    localparam int CW = $clog2(STEPS + 1);
    logic [SUM_W-1:0] r_num, r_q;
    logic [CNT_W:0] r_rem;
    logic [CNT_W-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic r_busy, r_done;
    logic [CNT_W:0] sh;

    assign sh = {r_rem[CNT_W-1:0], r_num[SUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num <= i_num;
                r_den <= i_den;
                r_rem <= '0;
                r_q <= '0;
                r_cnt <= CW'(STEPS);
            end else if (r_busy) begin
                r_num <= {r_num[SUM_W-2:0], 1'b0};
                if (sh >= {1'b0, r_den}) begin
                    r_rem <= sh - {1'b0, r_den};
                    r_q <= {r_q[SUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= sh;
                    r_q <= {r_q[SUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo = (r_q > SUM_W'(255)) ? 8'd255 : r_q[7:0];
endmodule
`default_nettype wire

### rtl/kmeans_color_cluster_engine.sv
`default_nettype none
// k-means color clustering engine.
// Input channel (i_in_valid/o_in_ready, payload i_in) carries one transaction
// per operation: load a center, classify a pixel, end a generation, or
// recolor by label. Every input transaction yields exactly one output
// transaction on o_out_valid/i_out_ready with payload o_out.
// Classify walks a chain of MAX_CENTERS cells, one center per cell, with the
// best-so-far distance token handed one cell per cycle. End of generation
// runs three restoring divisions per active center that has members, on a
// shared divider; an empty center is reseeded from the LFSR instead.
// One item is in flight at a time; the next input transaction is accepted as
// soon as the result sits in the output register, even while the receiver
// stalls. That item then holds its result until the register is taken.
// Reset (synchronous, active low) zeroes centers, sums and counts, loads the
// LFSR with the seed register value and restores registers to k=4, limit
// 100, seed 1. APB writes are taken with zero wait states; reads return the
// register value.
module kmeans_color_cluster_engine
    import kmcc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam logic [2:0] S_IDLE = 3'd0, S_CLS = 3'd1, S_DIV = 3'd2,
                           S_WAIT = 3'd3, S_UPD = 3'd4, S_FIN = 3'd5,
                           S_OUT = 3'd6;
    localparam int TW = $clog2(MAX_CENTERS + 2);

    logic [4:0] r_k;
    logic [15:0] r_limit, r_gen;
    logic [23:0] r_seed, r_lfsr;
    logic [2:0] r_state;
    t_in_item r_item;
    t_out_item r_out;
    logic r_ovld;
    logic [TW-1:0] r_tcnt;
    logic [IDX_W-1:0] r_ci;
    logic [1:0] r_ch;
    logic [23:0] r_newc;
    logic r_done_ok, r_start;

    // effective k
    logic [K_W-1:0] k_eff;
    always_comb begin
        if (r_k == '0) k_eff = K_W'(1);
        else if (32'(r_k) > MAX_CENTERS) k_eff = K_W'(MAX_CENTERS);
        else k_eff = K_W'(r_k);
    end

    // APB
    assign pready = 1'b1;
    always_comb begin
        case (paddr[3:2])
            REG_ACTIVE: prdata = {27'd0, r_k};
            REG_LIMIT:  prdata = {16'd0, r_limit};
            REG_SEED:   prdata = {8'd0, r_seed};
            default:    prdata = '0;
        endcase
    end
    logic wr;
    assign wr = psel && penable && pwrite;

    // cell chain
    t_cls_tok tok [MAX_CENTERS+1];
    t_cell_st st [MAX_CENTERS];
    t_cls_tok tok0;
    logic acc;
    assign acc = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // load the output register once it is free or being taken
    logic out_load;
    assign out_load = (r_state == S_OUT) && (!r_ovld || i_out_ready);

    always_comb begin
        tok0 = '0;
        tok0.vld = acc && i_in.func == FUNC_CLASSIFY;
        tok0.r = i_in.pixel_red;
        tok0.g = i_in.pixel_green;
        tok0.b = i_in.pixel_blue;
        tok0.best_d = (DIST_W+1)'(19'h7FFFF);
    end
    assign tok[0] = tok0;

    logic [IDX_W-1:0] best;
    assign best = tok[MAX_CENTERS].best;
    // cls_end flags the cycle in which the token leaves the last cell
    logic cls_end;
    assign cls_end = (r_state == S_CLS) && r_tcnt == TW'(MAX_CENTERS - 1);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_CENTERS; gi++) begin : g_cell
            t_cell_ctl ctl;
            always_comb begin
                ctl = '0;
                ctl.load = acc && i_in.func == FUNC_LOAD &&
                           i_in.center_index == 4'(gi);
                ctl.load_rgb = {i_in.pixel_red, i_in.pixel_green, i_in.pixel_blue};
                ctl.upd = (r_state == S_UPD) && r_tcnt != '0 && r_ci == IDX_W'(gi);
                ctl.upd_rgb = r_newc;
                ctl.clr = (r_state == S_FIN);
                ctl.add = cls_end && best == IDX_W'(gi);
                ctl.add_r = r_item.pixel_red;
                ctl.add_g = r_item.pixel_green;
                ctl.add_b = r_item.pixel_blue;
            end
            kmcc_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n),
                .i_my_idx(IDX_W'(gi)),
                .i_active(K_W'(gi) < k_eff),
                .i_tok(tok[gi]), .o_tok(tok[gi+1]),
                .i_ctl(ctl), .o_st(st[gi])
            );
        end
    endgenerate

    // divider operands for current center / channel
    logic [SUM_W-1:0] num;
    logic div_done;
    logic [7:0] quo;
    always_comb begin
        case (r_ch)
            2'd0: num = st[r_ci].rs;
            2'd1: num = st[r_ci].gs;
            default: num = st[r_ci].bs;
        endcase
    end
    kmcc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_num(num), .i_den(st[r_ci].cnt), .o_done(div_done), .o_quo(quo)
    );

    function automatic logic [23:0] lfsr_step(input logic [23:0] s);
        lfsr_step = s[0] ? ((s >> 1) ^ LFSR_MASK) : (s >> 1);
    endfunction

    logic [23:0] l1, l2, l3;
    assign l1 = lfsr_step(r_lfsr);
    assign l2 = lfsr_step(l1);
    assign l3 = lfsr_step(l2);

    logic [15:0] gen_inc;
    assign gen_inc = (r_gen != 16'hFFFF) ? r_gen + 1'b1 : r_gen;
    logic [23:0] sel_rgb;
    assign sel_rgb = st[r_item.center_index].rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= 5'd4;
            r_limit <= 16'd100;
            r_seed <= 24'd1;
            r_lfsr <= 24'd1;
            r_gen <= '0;
            r_state <= S_IDLE;
            r_ovld <= 1'b0;
            r_start <= 1'b0;
            r_tcnt <= '0;
            r_ci <= '0;
            r_ch <= '0;
            r_done_ok <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (out_load) r_ovld <= 1'b1;
            else if (i_out_ready) r_ovld <= 1'b0;
            if (wr) begin
                case (paddr[3:2])
                    REG_ACTIVE: r_k <= pwdata[4:0];
                    REG_LIMIT:  r_limit <= pwdata[15:0];
                    REG_SEED: begin
                        r_seed <= pwdata[23:0];
                        r_lfsr <= (pwdata[23:0] == '0) ? 24'd1 : pwdata[23:0];
                    end
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_item <= i_in;
                        r_tcnt <= '0;
                        r_ci <= '0;
                        r_ch <= '0;
                        r_done_ok <= 1'b1;
                        case (i_in.func)
                            FUNC_CLASSIFY: r_state <= S_CLS;
                            FUNC_ENDGEN: r_state <= S_UPD;
                            default: r_state <= S_OUT;
                        endcase
                        // endgen enters via S_UPD decision with no update yet
                    end
                end
                S_CLS: begin
                    r_tcnt <= r_tcnt + 1'b1;
                    if (cls_end) begin
                        // report the winner like a recolor of that center
                        r_item.center_index <= best;
                        r_state <= S_OUT;
                    end
                end
                S_UPD: begin
                    // first visit or after a center's update: dispatch center r_ci
                    if (r_tcnt != '0) begin
                        if (r_newc != st[r_ci].rgb) r_done_ok <= 1'b0;
                        r_ci <= r_ci + 1'b1;
                    end
                    r_tcnt <= TW'(1);
                    if (r_tcnt != '0 && K_W'(r_ci) + 1'b1 >= k_eff) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (st[r_ci].cnt == '0) begin
                        r_newc <= {l1[7:0], l2[7:0], l3[7:0]};
                        r_lfsr <= l3;
                        r_done_ok <= 1'b0;
                        r_state <= S_UPD;
                    end else begin
                        r_ch <= 2'd0;
                        r_start <= 1'b1;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (div_done) begin
                        case (r_ch)
                            2'd0: r_newc[23:16] <= quo;
                            2'd1: r_newc[15:8] <= quo;
                            default: r_newc[7:0] <= quo;
                        endcase
                        if (r_ch == 2'd2) begin
                            r_state <= S_UPD;
                        end else begin
                            r_ch <= r_ch + 1'b1;
                            r_start <= 1'b1;
                        end
                    end
                end
                S_FIN: begin
                    r_gen <= (r_done_ok || gen_inc >= r_limit) ? 16'd0 : gen_inc;
                    r_done_ok <= r_done_ok || gen_inc >= r_limit;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold here while the previous result still waits
                    if (out_load) begin
                        r_out <= '{label: r_item.center_index,
                                   center_red: sel_rgb[23:16],
                                   center_green: sel_rgb[15:8],
                                   center_blue: sel_rgb[7:0],
                                   converged: (r_item.func == FUNC_ENDGEN) && r_done_ok};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out = r_out;
endmodule
`default_nettype wire

### sim/tb_kmeans_color_cluster_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: holds the cluster state, predicts each result, checks outputs.
class kmcc_scoreboard;
    logic [4:0]  active_reg;
    logic [15:0] limit_reg;
    logic [23:0] lfsr;
    logic [23:0] centers [16];
    logic [27:0] rsum [16];
    logic [27:0] gsum [16];
    logic [27:0] bsum [16];
    logic [20:0] counts [16];
    logic [15:0] gen_count;
    kmcc_pkg::t_out_item pending [$];
    int errors;

    function void reset_state();
        active_reg = 5'd4;
        limit_reg = 16'd100;
        lfsr = 24'd1;
        gen_count = '0;
        errors = 0;
        for (int i = 0; i < 16; i++) begin
            centers[i] = '0;
        end
        clear_sums();
    endfunction

    function void clear_sums();
        for (int i = 0; i < 16; i++) begin
            rsum[i] = '0;
            gsum[i] = '0;
            bsum[i] = '0;
            counts[i] = '0;
        end
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            kmcc_pkg::REG_ACTIVE: active_reg = val[4:0];
            kmcc_pkg::REG_LIMIT:  limit_reg = val[15:0];
            kmcc_pkg::REG_SEED:   lfsr = (val[23:0] == 0) ? 24'd1 : val[23:0];
            default: ;
        endcase
    endfunction

    function int eff_k();
        if (active_reg == 0) return 1;
        if (active_reg > 16) return 16;
        return active_reg;
    endfunction

    // step the Galois LFSR and take its low byte
    function logic [7:0] draw();
        if (lfsr[0]) lfsr = (lfsr >> 1) ^ kmcc_pkg::LFSR_MASK;
        else lfsr = lfsr >> 1;
        return lfsr[7:0];
    endfunction

    // add a color component, saturating at the sum width
    function logic [27:0] sat_add(logic [27:0] s, logic [7:0] v);
        logic [28:0] t;
        t = {1'b0, s} + {21'd0, v};
        return t[28] ? 28'hfffffff : t[27:0];
    endfunction

    function logic end_generation();
        logic done;
        logic [23:0] nc;
        logic [27:0] q;
        done = 1'b1;
        for (int i = 0; i < eff_k(); i++) begin
            if (counts[i] != 0) begin
                q = rsum[i] / counts[i]; nc[23:16] = (q > 255) ? 8'hff : q[7:0];
                q = gsum[i] / counts[i]; nc[15:8] = (q > 255) ? 8'hff : q[7:0];
                q = bsum[i] / counts[i]; nc[7:0] = (q > 255) ? 8'hff : q[7:0];
                if (nc != centers[i]) done = 1'b0;
                centers[i] = nc;
            end else begin
                nc[23:16] = draw();
                nc[15:8] = draw();
                nc[7:0] = draw();
                centers[i] = nc;
                done = 1'b0;
            end
        end
        clear_sums();
        if (gen_count != 16'hffff) gen_count++;
        if (gen_count >= limit_reg) done = 1'b1;
        if (done) gen_count = '0;
        return done;
    endfunction

    function void note_input(kmcc_pkg::t_in_item it);
        kmcc_pkg::t_out_item res;
        int best, bd, d, dr, dg, db;
        logic [23:0] col;
        res = '0;
        res.label = it.center_index;
        col = centers[it.center_index];
        case (it.func)
            kmcc_pkg::FUNC_LOAD: begin
                centers[it.center_index] = {it.pixel_red, it.pixel_green, it.pixel_blue};
                col = centers[it.center_index];
            end
            kmcc_pkg::FUNC_CLASSIFY: begin
                best = 0;
                bd = 32'h1000000;
                for (int i = 0; i < eff_k(); i++) begin
                    dr = int'(centers[i][23:16]) - int'(it.pixel_red);
                    dg = int'(centers[i][15:8]) - int'(it.pixel_green);
                    db = int'(centers[i][7:0]) - int'(it.pixel_blue);
                    d = dr * dr + dg * dg + db * db;
                    if (d < bd) begin
                        bd = d;
                        best = i;
                    end
                end
                // hold count and sums once the count is full
                if (counts[best] != 21'h1fffff) begin
                    counts[best]++;
                    rsum[best] = sat_add(rsum[best], it.pixel_red);
                    gsum[best] = sat_add(gsum[best], it.pixel_green);
                    bsum[best] = sat_add(bsum[best], it.pixel_blue);
                end
                res.label = best[3:0];
                col = centers[best];
            end
            kmcc_pkg::FUNC_ENDGEN: begin
                res.converged = end_generation();
                col = centers[it.center_index];
            end
            default: ;
        endcase
        {res.center_red, res.center_green, res.center_blue} = col;
        pending.push_back(res);
    endfunction

    function void check_result(kmcc_pkg::t_out_item got);
        kmcc_pkg::t_out_item exp_r;
        if (pending.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got.label !== exp_r.label) begin
            $error("label exp %0d got %0d", exp_r.label, got.label); errors++;
        end
        if (got.center_red !== exp_r.center_red) begin
            $error("center_red exp %0d got %0d", exp_r.center_red, got.center_red); errors++;
        end
        if (got.center_green !== exp_r.center_green) begin
            $error("center_green exp %0d got %0d", exp_r.center_green, got.center_green);
            errors++;
        end
        if (got.center_blue !== exp_r.center_blue) begin
            $error("center_blue exp %0d got %0d", exp_r.center_blue, got.center_blue);
            errors++;
        end
        if (got.converged !== exp_r.converged) begin
            $error("converged exp %0d got %0d", exp_r.converged, got.converged); errors++;
        end
    endfunction
endclass

module tb_kmeans_color_cluster_engine;
    import kmcc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    kmcc_scoreboard cluster_sb;
    bit  idle_off;      // last part of the run: no bubbles on either side
    bit  hold_sink;     // long receiver stall in progress
    int  quiet_cycles;

    localparam int QUIET_LIMIT = 20000;

    kmeans_color_cluster_engine dut (.*);

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // Watchdog: count cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: check each accepted transaction, toggle ready with random bursts.
    int sink_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (o_out_valid && i_out_ready) cluster_sb.check_result(o_out);
            if (hold_sink) begin
                i_out_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap = sink_gap - 1;
                i_out_ready <= 1'b0;
            end else if (!idle_off && $urandom_range(0, 4) == 0) begin
                sink_gap = $urandom_range(0, 5);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Present one transaction and hold it until accepted; optional bubble first.
    // Valid stays high after acceptance; the caller drops it when traffic pauses.
    task automatic send_item(input t_in_item it);
        int gap;
        if (!idle_off && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        cluster_sb.note_input(it);
    endtask

    task automatic send(input logic [1:0] f, input logic [3:0] idx,
                        input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        t_in_item it;
        it.func = f;
        it.center_index = idx;
        it.pixel_red = r;
        it.pixel_green = g;
        it.pixel_blue = b;
        send_item(it);
    endtask

    // Drop valid, drain all outstanding results, then let the engine settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (cluster_sb.pending.size() != 0) @(posedge i_clk);
        repeat (1600) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        cluster_sb.write_reg(idx, val);
    endtask

    task automatic config_all(input logic [4:0] k, input logic [15:0] lim,
                              input logic [23:0] seed);
        wait_idle();
        apb_write(REG_ACTIVE, {27'd0, k});
        apb_write(REG_LIMIT, {16'd0, lim});
        apb_write(REG_SEED, {8'd0, seed});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Random traffic: a random mix of loads, pixels, generation ends and recolors, mostly pixels.
    task automatic random_phase(input int n);
        int sent;
        t_in_item it;
        logic [1:0] f;
        sent = 0;
        while (sent < n) begin
            it.center_index = 4'($urandom_range(0, 15));
            it.pixel_red = 8'($urandom_range(0, 255));
            it.pixel_green = 8'($urandom_range(0, 255));
            it.pixel_blue = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 19))
                0, 1:    f = FUNC_LOAD;
                2:       f = FUNC_ENDGEN;
                3:       f = FUNC_RECOLOR;
                default: f = FUNC_CLASSIFY;
            endcase
            it.func = f;
            send_item(it);
            sent++;
        end
    endtask

    initial begin
        cluster_sb = new();
        cluster_sb.reset_state();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_off = 1'b0;
        hold_sink = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset-value engine, loads at the extremes, every operation.
        send(FUNC_CLASSIFY, 4'd0, 8'd0, 8'd0, 8'd0);
        send(FUNC_ENDGEN, 4'd0, 8'd0, 8'd0, 8'd0);
        send(FUNC_LOAD, 4'd0, 8'h00, 8'h00, 8'h00);
        send(FUNC_LOAD, 4'd1, 8'hff, 8'hff, 8'hff);
        send(FUNC_LOAD, 4'd2, 8'hff, 8'h00, 8'hff);
        send(FUNC_LOAD, 4'd3, 8'h00, 8'hff, 8'h00);
        send(FUNC_LOAD, 4'd15, 8'h80, 8'h7f, 8'h01);
        send(FUNC_RECOLOR, 4'd15, 8'd0, 8'd0, 8'd0);
        send(FUNC_CLASSIFY, 4'd9, 8'hff, 8'hff, 8'hff);
        send(FUNC_CLASSIFY, 4'd0, 8'h80, 8'h80, 8'h80);   // near tie, center 1 is closest
        send(FUNC_CLASSIFY, 4'd0, 8'h00, 8'h00, 8'h00);
        send(FUNC_CLASSIFY, 4'd0, 8'hff, 8'h00, 8'hfe);
        send(FUNC_ENDGEN, 4'd1, 8'd0, 8'd0, 8'd0);       // center 3 empty: reseed
        send(FUNC_RECOLOR, 4'd3, 8'd0, 8'd0, 8'd0);
        send(FUNC_ENDGEN, 4'd15, 8'd0, 8'd0, 8'd0);

        // k = 0 acts as 1, limit 0 forces convergence, zero seed acts as 1.
        config_all(5'd0, 16'd0, 24'd0);
        send(FUNC_CLASSIFY, 4'd0, 8'h12, 8'h34, 8'h56);
        send(FUNC_ENDGEN, 4'd0, 8'd0, 8'd0, 8'd0);
        send(FUNC_ENDGEN, 4'd0, 8'd0, 8'd0, 8'd0);
        // k above MAX_CENTERS acts as MAX_CENTERS.
        config_all(5'd31, 16'd65535, 24'hffffff);
        send(FUNC_CLASSIFY, 4'd0, 8'h80, 8'h7f, 8'h01);
        send(FUNC_ENDGEN, 4'd0, 8'd0, 8'd0, 8'd0);

        config_all(5'd16, 16'd3, 24'h5a5a5a);
        random_phase(130);

        // Long receiver stall while the sender keeps offering.
        fork
            begin
                hold_sink = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            begin
                random_phase(30);
                i_in_valid <= 1'b0;
            end
        join

        config_all(5'd2, 16'd1, 24'h000001);
        random_phase(110);
        config_all(5'd7, 16'd5, 24'h123456);
        random_phase(110);
        config_all(5'd1, 16'd65535, 24'h800000);
        random_phase(40);
        idle_off = 1'b1;
        config_all(5'd4, 16'd100, 24'h00beef);
        random_phase(80);
        i_in_valid <= 1'b0;

        while (cluster_sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (cluster_sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

`default_nettype wire
